[hw/rtl/dent_pkg.sv]
package dent_pkg;

	// Sizing of the city set and of the stored distances.
	localparam int MAX_NODES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int ADDR_W    = 2 * NODE_W;
	localparam int DIST_W    = 16;
	localparam int COST_W    = 22;
	localparam int CFG_W     = 7;

	// Sizing of the command queue between the front and the back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	// Meaning of the mode field of an input word.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TOUR = 1'b1;

	typedef logic [NODE_W-1:0] node_t;

	// One classified command as it waits between the front and the back end.
	typedef struct packed {
		logic              is_tour;
		logic [ADDR_W-1:0] addr;
		logic [DIST_W-1:0] dist_val;
		node_t             start;
	} dent_cmd_t;

	// The city count in use is held between two and the maximum.
	function automatic logic [CNT_W-1:0] clamp_nodes(input logic [CFG_W-1:0] raw);
		logic [CNT_W-1:0] n;
		n = CNT_W'(raw);
		if (raw < CFG_W'(2)) begin
			n = CNT_W'(2);
		end else if (raw > CFG_W'(MAX_NODES)) begin
			n = CNT_W'(MAX_NODES);
		end
		return n;
	endfunction

endpackage

[hw/rtl/dent_in_if.sv]
interface dent_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [dent_pkg::NODE_W-1:0] row_node;
	logic [dent_pkg::NODE_W-1:0] col_node;
	logic [dent_pkg::DIST_W-1:0] distance_value;
	logic [dent_pkg::NODE_W-1:0] start_node;

	modport source (
		output valid, mode, row_node, col_node, distance_value, start_node,
		input  ready
	);

	modport sink (
		input  valid, mode, row_node, col_node, distance_value, start_node,
		output ready
	);
endinterface

[hw/rtl/dent_out_if.sv]
interface dent_out_if;
	logic                        valid;
	logic                        ready;
	logic [dent_pkg::NODE_W-1:0] tour_position;
	logic [dent_pkg::NODE_W-1:0] tour_city;
	logic [dent_pkg::COST_W-1:0] tour_cost;
	logic                        last_city;

	modport source (
		output valid, tour_position, tour_city, tour_cost, last_city,
		input  ready
	);

	modport sink (
		input  valid, tour_position, tour_city, tour_cost, last_city,
		output ready
	);
endinterface

[hw/rtl/double_ended_nearest_neighbor_tour_unit.sv]
// Greedy double-ended nearest-neighbour tour builder. A word with mode 0 writes one
// entry of the 64 x 64 distance memory through the back end; entries
// must be written before a tour reads them. A word with mode 1 builds a closed tour
// over the first n cities (n from the node_count register, held to 2..64) from the
// start city, saturated to n-1. Each of the n-1 growth steps reads 2n distances
// through the single read port of the distance memory, one a cycle, from the back
// end and then the front end, and commits the pick. The n result words follow front
// to back, each carrying the total cost and a last marker on the final city. A
// two-word queue sits between the accepting front end and the executing back end,
// which takes no new word until a tour has finished. The user must write node_count
// only while the block is idle; the block itself does not enforce it.
module double_ended_nearest_neighbor_tour_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dent_pkg::CFG_W-1:0] cfg_wdata,
	dent_in_if.sink                    items,
	dent_out_if.source                 results
);
	import dent_pkg::*;

	logic [CFG_W-1:0] node_count_q;
	logic [CNT_W-1:0] n_eff;
	logic             cmd_valid;
	dent_cmd_t        cmd;
	logic             cmd_pop;

	// City count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(MAX_NODES);
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	assign n_eff = clamp_nodes(node_count_q);

	dent_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_eff     (n_eff),
		.items     (items),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	dent_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_eff     (n_eff),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.results   (results)
	);
endmodule

[hw/rtl/dent_ram.sv]
module dent_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/dent_front.sv]
module dent_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [dent_pkg::CNT_W-1:0] n_eff,
	dent_in_if.sink                    items,
	output logic                       cmd_valid,
	output dent_pkg::dent_cmd_t        cmd,
	input  logic                       cmd_pop
);
	import dent_pkg::*;

	dent_cmd_t         queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	dent_cmd_t         entry;

	assign items.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push        = items.valid && items.ready;
	assign cmd_valid   = (count_q != '0);
	assign cmd         = queue_q[rd_ptr_q];

	// Classify the incoming word and saturate the start city to the count in use.
	always_comb begin
		entry.is_tour  = (items.mode == MODE_TOUR);
		entry.addr     = {items.row_node, items.col_node};
		entry.dist_val = items.distance_value;
		if (CNT_W'(items.start_node) >= n_eff) begin
			entry.start = NODE_W'(n_eff - CNT_W'(1));
		end else begin
			entry.start = items.start_node;
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && cmd_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end
endmodule

[hw/rtl/dent_back.sv]
module dent_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [dent_pkg::CNT_W-1:0] n_eff,
	input  logic                       cmd_valid,
	input  dent_pkg::dent_cmd_t        cmd,
	output logic                       cmd_pop,
	dent_out_if.source                 results
);
	import dent_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DRAIN, ST_COMMIT, ST_CLOSE_RD, ST_CLOSE_ADD, ST_EMIT
	} state_t;

	state_t              state_q;
	logic [MAX_NODES-1:0] visited_q;
	node_t               head_q, tail_q, front_q, back_q;
	node_t               step_q, scan_j_q, k_q;
	logic                scan_side_q;
	logic                v_s1, side_s1;
	node_t               j_s1;
	logic                found_q, at_front_q;
	logic [DIST_W-1:0]   best_q;
	node_t               pick_q;
	logic [COST_W-1:0]   cost_q;
	logic                data_ok_q;
	logic                out_valid_q, out_last_q;
	node_t               out_pos_q, out_city_q;
	logic [COST_W-1:0]   out_cost_q;

	node_t               n_m1;
	logic                dist_we;
	logic [ADDR_W-1:0]   dist_raddr;
	logic [DIST_W-1:0]   dist_rdata;
	logic                ring_we;
	node_t               ring_waddr, ring_wdata, ring_raddr, ring_rdata;
	node_t               s1_from;
	logic                take;
	logic                out_free;
	logic                out_load;
	logic [COST_W:0]     close_sum;
	logic [COST_W-1:0]   close_cost;

	assign n_m1 = NODE_W'(n_eff - CNT_W'(1));

	// Distance memory: loads write it, the scan and the closing edge read it.
	assign dist_we    = (state_q == ST_IDLE) && cmd_valid && !cmd.is_tour;
	assign dist_raddr = (state_q == ST_SCAN)
		? {(scan_side_q ? front_q : back_q), scan_j_q} : {back_q, front_q};

	dent_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES * MAX_NODES)) u_dist (
		.clk   (clk),
		.we    (dist_we),
		.waddr (cmd.addr),
		.wdata (cmd.dist_val),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	// Tour ring: the start city goes in at slot zero, each pick beside one end.
	always_comb begin
		if (state_q == ST_IDLE) begin
			ring_we    = cmd_valid && cmd.is_tour;
			ring_waddr = '0;
			ring_wdata = cmd.start;
		end else begin
			ring_we    = (state_q == ST_COMMIT);
			ring_waddr = at_front_q ? (head_q - NODE_W'(1)) : (tail_q + NODE_W'(1));
			ring_wdata = pick_q;
		end
	end

	assign ring_raddr = head_q + k_q;

	dent_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// Candidate compare: the back end keeps the lowest index on a tie,
	// and the front end only takes over when strictly nearer.
	assign s1_from = side_s1 ? front_q : back_q;
	assign take    = v_s1 && (j_s1 != s1_from) && !visited_q[j_s1]
		&& (!found_q || (dist_rdata < best_q));

	// Closing edge with saturation.
	assign close_sum  = {1'b0, cost_q} + (COST_W + 1)'(dist_rdata);
	assign close_cost = close_sum[COST_W] ? COST_MAX : close_sum[COST_W-1:0];

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign out_free = !out_valid_q || results.ready;
	assign out_load = (state_q == ST_EMIT) && data_ok_q && out_free;

	assign results.valid         = out_valid_q;
	assign results.tour_position = out_pos_q;
	assign results.tour_city     = out_city_q;
	assign results.tour_cost     = out_cost_q;
	assign results.last_city     = out_last_q;

	// Sequencer, scan pipeline and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			visited_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			front_q     <= '0;
			back_q      <= '0;
			step_q      <= '0;
			scan_j_q    <= '0;
			k_q         <= '0;
			scan_side_q <= 1'b0;
			v_s1        <= 1'b0;
			side_s1     <= 1'b0;
			j_s1        <= '0;
			found_q     <= 1'b0;
			at_front_q  <= 1'b0;
			best_q      <= '0;
			pick_q      <= '0;
			cost_q      <= '0;
			data_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_pos_q   <= '0;
			out_city_q  <= '0;
			out_cost_q  <= '0;
		end else begin
			// The output word is refilled or handed over.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				found_q <= 1'b1;
				best_q  <= dist_rdata;
				pick_q  <= j_s1;
				if (side_s1) begin
					at_front_q <= 1'b1;
				end
			end
			v_s1 <= (state_q == ST_SCAN);

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd.is_tour) begin
						visited_q   <= MAX_NODES'(1) << cmd.start;
						head_q      <= '0;
						tail_q      <= '0;
						front_q     <= cmd.start;
						back_q      <= cmd.start;
						cost_q      <= '0;
						step_q      <= NODE_W'(1);
						scan_j_q    <= '0;
						scan_side_q <= 1'b0;
						found_q     <= 1'b0;
						at_front_q  <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					j_s1    <= scan_j_q;
					side_s1 <= scan_side_q;
					if (scan_j_q == n_m1) begin
						if (scan_side_q) begin
							state_q <= ST_DRAIN;
						end else begin
							scan_side_q <= 1'b1;
							scan_j_q    <= '0;
						end
					end else begin
						scan_j_q <= scan_j_q + NODE_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					visited_q[pick_q] <= 1'b1;
					if (at_front_q) begin
						head_q  <= head_q - NODE_W'(1);
						front_q <= pick_q;
					end else begin
						tail_q <= tail_q + NODE_W'(1);
						back_q <= pick_q;
					end
					cost_q <= cost_q + COST_W'(best_q);
					if (step_q == n_m1) begin
						state_q <= ST_CLOSE_RD;
					end else begin
						step_q      <= step_q + NODE_W'(1);
						scan_j_q    <= '0;
						scan_side_q <= 1'b0;
						found_q     <= 1'b0;
						at_front_q  <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_CLOSE_RD: begin
					state_q <= ST_CLOSE_ADD;
				end
				ST_CLOSE_ADD: begin
					cost_q    <= close_cost;
					k_q       <= '0;
					data_ok_q <= 1'b0;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (data_ok_q && out_free) begin
						out_pos_q  <= k_q;
						out_city_q <= ring_rdata;
						out_cost_q <= cost_q;
						out_last_q <= (k_q == n_m1);
						data_ok_q  <= 1'b0;
						if (k_q == n_m1) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + NODE_W'(1);
						end
					end else begin
						data_ok_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

[hw/rtl/dent_checker.sv]
module dent_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [dent_pkg::NODE_W-1:0] res_position,
	input logic [dent_pkg::NODE_W-1:0] res_city,
	input logic [dent_pkg::COST_W-1:0] res_cost,
	input logic                        res_last
);
	// A stalled result word stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word withdrawn while stalled");

	// A stalled result word keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_position) && $stable(res_city)
			&& $stable(res_cost) && $stable(res_last))
		else $error("result payload changed while stalled");

	// A tour has at least two cities, so the front city is never the last one.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_position == '0) |-> !res_last)
		else $error("last marker on the front city");

	// Nothing is offered straight out of reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !res_valid)
		else $error("result offered straight after reset");
endmodule

bind double_ended_nearest_neighbor_tour_unit dent_checker u_dent_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (results.valid),
	.res_ready    (results.ready),
	.res_position (results.tour_position),
	.res_city     (results.tour_city),
	.res_cost     (results.tour_cost),
	.res_last     (results.last_city)
);

[dv/tb_double_ended_nearest_neighbor_tour_unit.sv]
`timescale 1ns / 1ps

module tb_double_ended_nearest_neighbor_tour_unit;
	import dent_pkg::*;

	localparam int          DRAIN_CYCLES  = 16;
	localparam int          RANDOM_WORDS  = 200;
	localparam int          LARGE_CITIES  = 16;
	localparam longint      TIMEOUT_NS    = 4_000_000;

	// One city of a finished tour as the block should report it.
	typedef struct packed {
		node_t             position;
		node_t             city;
		logic [COST_W-1:0] cost;
		logic              last;
	} tour_stop_t;

	typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_FLAT} spread_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	dent_in_if  items ();
	dent_out_if results ();

	double_ended_nearest_neighbor_tour_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items.sink),
		.results   (results.source)
	);

	// Mirror of the block's distance memory and city count register.
	logic [DIST_W-1:0] leg_len [MAX_NODES][MAX_NODES];
	logic [CFG_W-1:0]  city_reg;
	tour_stop_t        stops_due [$];

	bit          steady_send;
	bit          steady_take;
	int unsigned failures;
	int unsigned loads_sent;
	int unsigned tours_sent;
	int unsigned stops_checked;
	int unsigned widest_tour;

	always #2 clk = ~clk;

	// City count in use, held between two and the maximum.
	function automatic int unsigned cities_in_use();
		if (city_reg < 2)
			return 2;
		if (city_reg > MAX_NODES)
			return MAX_NODES;
		return city_reg;
	endfunction

	function automatic int unsigned pause_len(input bit steady);
		if (steady)
			return 0;
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
	endfunction

	// Greedy tour from the seed city, growing at whichever end offers the nearer city.
	function automatic void plan_tour(input node_t seed);
		int unsigned n;
		int unsigned step;
		int unsigned j;
		int unsigned e;
		int unsigned pick;
		logic [DIST_W-1:0] best;
		logic [31:0] sum;
		int unsigned route [$];
		bit seen [MAX_NODES];
		bit found;
		bit from_front;
		int unsigned ends [2];
		tour_stop_t stop;
		n = cities_in_use();
		route = {};
		route.insert(0, (seed >= n) ? n - 1 : int'(seed));
		seen = '{default: 1'b0};
		seen[route[0]] = 1'b1;
		sum = '0;
		for (step = 1; step < n; step++) begin
			found = 1'b0;
			from_front = 1'b0;
			best = '0;
			pick = 0;
			ends[0] = route[route.size() - 1];
			ends[1] = route[0];
			// The back end is scanned first; the front end must be strictly nearer.
			for (e = 0; e < 2; e++) begin
				for (j = 0; j < n; j++) begin
					if (j != ends[e] && !seen[j] &&
					    (!found || leg_len[ends[e]][j] < best)) begin
						found = 1'b1;
						best = leg_len[ends[e]][j];
						pick = j;
						from_front = (e == 1);
					end
				end
			end
			seen[pick] = 1'b1;
			if (from_front)
				route.insert(0, pick);
			else
				route.insert(route.size(), pick);
			sum += best;
		end
		sum += leg_len[route[route.size() - 1]][route[0]];
		if (sum > COST_MAX)
			sum = COST_MAX;
		for (j = 0; j < n; j++) begin
			stop.position = node_t'(j);
			stop.city     = node_t'(route[j]);
			stop.cost     = sum[COST_W-1:0];
			stop.last     = (j == n - 1);
			stops_due.insert(stops_due.size(), stop);
		end
		if (n > widest_tour)
			widest_tour = n;
	endfunction

	// Presents one word and waits until the block takes it.
	task automatic send_word(input logic mode, input node_t row, input node_t col,
	                         input logic [DIST_W-1:0] len, input node_t seed);
		int unsigned gap;
		gap = pause_len(steady_send);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid          <= 1'b1;
		items.mode           <= mode;
		items.row_node       <= row;
		items.col_node       <= col;
		items.distance_value <= len;
		items.start_node     <= seed;
		do @(posedge clk); while (items.ready !== 1'b1);
		if (mode == MODE_LOAD) begin
			leg_len[row][col] = len;
			loads_sent++;
		end else begin
			plan_tour(seed);
			tours_sent++;
		end
	endtask

	task automatic load_leg(input node_t row, input node_t col, input logic [DIST_W-1:0] len);
		send_word(MODE_LOAD, row, col, len, node_t'($urandom));
	endtask

	task automatic start_tour(input node_t seed);
		send_word(MODE_TOUR, node_t'($urandom), node_t'($urandom), DIST_W'($urandom), seed);
	endtask

	// Holds the sender back until every city of every tour has come out.
	task automatic settle_block();
		items.valid <= 1'b0;
		while (stops_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_cities(input logic [CFG_W-1:0] raw);
		settle_block();
		cfg_wdata <= raw;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we   <= 1'b0;
		city_reg = raw;
	endtask

	// Two cities: extreme distances, a diagonal entry beyond the count, a clamped start.
	task automatic test_two_cities();
		program_cities(7'd2);
		load_leg(6'd0, 6'd1, '0);
		load_leg(6'd1, 6'd0, '1);
		load_leg(6'd63, 6'd63, 16'h5A5A);
		start_tour(6'd0);
		start_tour(6'd63);
	endtask

	// All distances equal: the back end keeps the lowest index and the front never wins.
	task automatic test_equal_distances();
		int unsigned r;
		int unsigned c;
		program_cities(7'd3);
		for (r = 0; r < 3; r++)
			for (c = 0; c < 3; c++)
				if (r != c)
					load_leg(node_t'(r), node_t'(c), 16'd5);
		start_tour(6'd1);
	endtask

	// The front end offers a strictly nearer city on the second step.
	task automatic test_front_end_wins();
		load_leg(6'd1, 6'd2, 16'd2);
		load_leg(6'd1, 6'd0, 16'd4);
		load_leg(6'd2, 6'd0, 16'd9);
		start_tour(6'd1);
	endtask

	// Counts below two act as two.
	task automatic test_count_clamping();
		program_cities(7'd1);
		start_tour(6'd63);
		program_cities(7'd0);
		start_tour(6'd5);
	endtask

	// Full matrix over sixteen cities, then tours from both ends of the range
	// and one from a start city beyond the count.
	task automatic test_largest_instance();
		int unsigned r;
		int unsigned c;
		program_cities(CFG_W'(LARGE_CITIES));
		steady_send = 1'b0;
		for (r = 0; r < LARGE_CITIES; r++)
			for (c = 0; c < LARGE_CITIES; c++)
				load_leg(node_t'(r), node_t'(c), ($urandom_range(0, 7) == 0) ?
				         DIST_W'($urandom_range(0, 3)) : DIST_W'($urandom));
		start_tour(6'd0);
		start_tour(node_t'(LARGE_CITIES - 1));
		start_tour(6'd63);
	endtask

	// Phases of one city count: reload the block in use if n <= 12, then one or more tours.
	task automatic test_random_phases();
		int unsigned first_word;
		int unsigned n;
		int unsigned r;
		int unsigned c;
		int unsigned k;
		int unsigned laps;
		logic [DIST_W-1:0] flat;
		spread_t spread;
		first_word = loads_sent + tours_sent;
		while (loads_sent + tours_sent - first_word < RANDOM_WORDS) begin
			case ($urandom_range(0, 19))
				0:       program_cities(CFG_W'($urandom_range(0, 1)));
				1, 2:    program_cities(CFG_W'($urandom_range(11, LARGE_CITIES)));
				default: program_cities(CFG_W'($urandom_range(2, 10)));
			endcase
			n = cities_in_use();
			steady_send = ($urandom_range(0, 3) == 0);
			steady_take = ($urandom_range(0, 3) == 0);
			if (n <= 12) begin
				spread = spread_t'($urandom_range(0, 2));
				flat = DIST_W'($urandom);
				for (r = 0; r < n; r++)
					for (c = 0; c < n; c++)
						if (r != c)
							case (spread)
								SPREAD_FULL:   load_leg(node_t'(r), node_t'(c), DIST_W'($urandom));
								SPREAD_NARROW: load_leg(node_t'(r), node_t'(c),
								                        DIST_W'($urandom_range(0, 3)));
								default:       load_leg(node_t'(r), node_t'(c), flat);
							endcase
				laps = $urandom_range(2, 5);
			end else begin
				laps = $urandom_range(1, 2);
			end
			for (k = 0; k < laps; k++) begin
				// Stray loads anywhere in the memory, between tours.
				repeat ($urandom_range(0, 3))
					load_leg(node_t'($urandom), node_t'($urandom), DIST_W'($urandom));
				if ($urandom_range(0, 5) == 0)
					settle_block();
				if ($urandom_range(0, 9) < 7)
					start_tour(node_t'($urandom_range(0, n - 1)));
				else
					start_tour(node_t'($urandom));
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// Result side: random back-pressure, each word compared with the oldest tour stop.
	initial begin
		tour_stop_t want;
		int unsigned stall;
		results.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pause_len(steady_take);
			if (stall > 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (results.valid !== 1'b1);
			if (stops_due.size() == 0) begin
				$display("%0t: result word with no tour stop pending, expected none, actual %0d/%0d",
				         $time, results.tour_position, results.tour_city);
				failures++;
			end else begin
				want = stops_due.pop_front();
				check_field("tour_position", want.position, results.tour_position);
				check_field("tour_city", want.city, results.tour_city);
				check_field("tour_cost", want.cost, results.tour_cost);
				check_field("last_city", want.last, results.last_city);
				stops_checked++;
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("** double_ended_nearest_neighbor_tour_unit: FAILED **");
		$finish;
	end

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		items.valid          = 1'b0;
		items.mode           = MODE_LOAD;
		items.row_node       = '0;
		items.col_node       = '0;
		items.distance_value = '0;
		items.start_node     = '0;
		city_reg             = 7'd64;
		failures             = 0;
		loads_sent           = 0;
		tours_sent           = 0;
		stops_checked        = 0;
		widest_tour          = 0;
		steady_send          = 1'b0;
		steady_take          = 1'b0;
		for (int r = 0; r < MAX_NODES; r++)
			for (int c = 0; c < MAX_NODES; c++)
				leg_len[r][c] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_two_cities();
		test_equal_distances();
		test_front_end_wins();
		test_count_clamping();
		test_largest_instance();
		test_random_phases();
		settle_block();

		if (stops_due.size() != 0) begin
			$display("%0t: %0d tour stops never reported", $time, stops_due.size());
			failures++;
		end
		$display("Sent %0d distance words and %0d tour starts; %0d tour cities checked.",
		         loads_sent, tours_sent, stops_checked);
		$display("City counts from 2 up to %0d, including clamped counts and start cities.",
		         widest_tour);
		if (failures == 0) begin
			$display("** double_ended_nearest_neighbor_tour_unit: PASSED **");
		end else begin
			$display("** double_ended_nearest_neighbor_tour_unit: FAILED **");
		end
		$finish;
	end

endmodule
